// ===== hw/rtl/cit_pkg.sv =====
`timescale 1ns / 1ps
package cit_pkg;

  localparam int unsigned IdW          = 29;
  localparam int unsigned CountW       = 4;
  localparam int unsigned DataW        = 64;
  localparam int unsigned HitsW        = 32;
  localparam int unsigned SlotW        = 7;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned DefTableDepth = 128;

  localparam logic [CountW-1:0] MaxBytes = CountW'(8);
  localparam logic [HitsW-1:0]  HitsMax  = '1;

  typedef struct packed {
    logic [IdW-1:0]    frame_id;
    logic [CountW-1:0] byte_count;
    logic [DataW-1:0]  payload;
  } cit_req_t;

  typedef struct packed {
    logic             tracked;
    logic [SlotW-1:0] slot;
    logic             first_seen;
    logic             changed;
    logic [HitsW-1:0] hit_count;
  } cit_rsp_t;

  typedef struct packed {
    logic [IdW-1:0] command_id_a;
    logic [IdW-1:0] command_id_b;
  } cit_cfg_t;

  typedef struct packed {
    logic [HitsW-1:0] hits;
    logic [DataW-1:0] bytes;
  } cit_entry_t;

  typedef enum logic [0:0] {
    RegCmdA,
    RegCmdB
  } cit_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StRead,
    StUpdate
  } cit_state_e;

  // Mask covering the low n bytes of the payload.
  function automatic logic [DataW-1:0] byte_mask(input logic [CountW-1:0] n);
    logic [DataW-1:0] m;
    m = '0;
    for (int b = 0; b < DataW / 8; b++) begin
      m[b*8 +: 8] = {8{CountW'(b) < n}};
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/can_id_change_tracker.sv =====
`timescale 1ns / 1ps
// Tracks CAN identifiers in a table of TableDepth entries held in two
// memories with registered read ports, one for identifiers and one for the
// stored payload and hit counter. A frame walks the occupied identifier
// entries one read per cycle until it finds a match or passes the fill count.
// One frame is in work at a time, and the next request is taken while the
// last result still waits in the output register. Unknown identifiers are
// appended while there is room; the table is never cleared, and a new entry's
// stored payload and hit counter are taken as zero, so no clearing pass
// follows reset.
module can_id_change_tracker #(
  parameter int unsigned TableDepth = cit_pkg::DefTableDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cit_pkg::cit_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cit_pkg::cit_rsp_t             out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cit_pkg::ApbAddrW-1:0]  paddr,
  input  logic [cit_pkg::ApbDataW-1:0]  pwdata,
  output logic [cit_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import cit_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned OccW = $clog2(TableDepth + 1);
  localparam logic [OccW-1:0] DepthOcc = OccW'(TableDepth);

  cit_cfg_t   cfg;
  cit_state_e state_q, state_d;
  cit_req_t   req_q, req_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] scan_q, scan_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            fresh_q, fresh_d;
  logic            tracked_q, tracked_d;
  logic            out_valid_q, out_valid_d;
  cit_rsp_t        out_rsp_q, out_rsp_d;

  logic            id_we, id_re;
  logic [IdxW-1:0] id_waddr;
  logic [IdW-1:0]  id_rdata;
  logic            ent_we, ent_re;
  cit_entry_t      ent_rdata, ent_new;
  logic            changed;
  logic            hit;
  logic [IdxW+SlotW-1:0] slot_ext;

  cit_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cit_ram #(
    .Width (IdW),
    .Depth (TableDepth)
  ) u_ident_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (id_waddr),
    .wdata_i (req_q.frame_id),
    .re_i    (id_re),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (id_rdata)
  );

  cit_ram #(
    .Width ($bits(cit_entry_t)),
    .Depth (TableDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (idx_q),
    .wdata_i (ent_new),
    .re_i    (ent_re),
    .raddr_i (idx_q),
    .rdata_o (ent_rdata)
  );

  cit_update u_update (
    .req_i     (req_q),
    .cfg_i     (cfg),
    .old_i     (ent_rdata),
    .fresh_i   (fresh_q),
    .new_o     (ent_new),
    .changed_o (changed)
  );

  assign hit      = pend_q && (id_rdata == req_q.frame_id);
  assign id_waddr = occ_q[IdxW-1:0];
  assign slot_ext = {{SlotW{1'b0}}, idx_q};

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    occ_d       = occ_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    idx_d       = idx_q;
    fresh_d     = fresh_q;
    tracked_d   = tracked_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    in_ready_o  = 1'b0;
    id_we       = 1'b0;
    id_re       = 1'b0;
    ent_we      = 1'b0;
    ent_re      = 1'b0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_req_i;
          scan_d  = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (hit) begin
          idx_d     = cmp_idx_q;
          fresh_d   = 1'b0;
          tracked_d = 1'b1;
          state_d   = StRead;
        end else if (scan_q < occ_q) begin
          // Issue the next identifier read; compare it next cycle.
          id_re     = 1'b1;
          pend_d    = 1'b1;
          cmp_idx_d = scan_q[IdxW-1:0];
          scan_d    = scan_q + OccW'(1);
        end else if (occ_q < DepthOcc) begin
          id_we     = 1'b1;
          idx_d     = occ_q[IdxW-1:0];
          occ_d     = occ_q + OccW'(1);
          fresh_d   = 1'b1;
          tracked_d = 1'b1;
          state_d   = StUpdate;
        end else begin
          // Table full: drop tracking for this identifier.
          idx_d     = '0;
          fresh_d   = 1'b0;
          tracked_d = 1'b0;
          state_d   = StUpdate;
        end
      end
      StRead: begin
        ent_re  = 1'b1;
        state_d = StUpdate;
      end
      StUpdate: begin
        if (!out_valid_q || out_ready_i) begin
          ent_we      = tracked_q;
          out_valid_d = 1'b1;
          if (tracked_q) begin
            out_rsp_d.tracked    = 1'b1;
            out_rsp_d.slot       = slot_ext[SlotW-1:0];
            out_rsp_d.first_seen = fresh_q;
            out_rsp_d.changed    = changed;
            out_rsp_d.hit_count  = ent_new.hits;
          end else begin
            out_rsp_d = '0;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      occ_q       <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cmp_idx_q <= cmp_idx_d;
    idx_q     <= idx_d;
    fresh_q   <= fresh_d;
    tracked_q <= tracked_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in work");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DepthOcc)
    else $error("fill count beyond table depth");

  a_first_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.first_seen |->
      out_rsp_o.tracked && out_rsp_o.hit_count == HitsW'(1))
    else $error("new entry without a single hit");

  a_tracked_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.tracked |-> out_rsp_o.hit_count != '0)
    else $error("tracked result with zero hit count");

endmodule

// ===== hw/rtl/cit_ram.sv =====
`timescale 1ns / 1ps
module cit_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cit_apb_regs.sv =====
`timescale 1ns / 1ps
module cit_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cit_pkg::ApbAddrW-1:0]  paddr,
  input  logic [cit_pkg::ApbDataW-1:0]  pwdata,
  output logic [cit_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output cit_pkg::cit_cfg_t             cfg_o
);
  import cit_pkg::*;

  cit_cfg_t cfg_q, cfg_d;
  cit_reg_e sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = cit_reg_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        RegCmdA: cfg_d.command_id_a = pwdata[IdW-1:0];
        RegCmdB: cfg_d.command_id_b = pwdata[IdW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegCmdA: prdata = ApbDataW'(cfg_q.command_id_a);
      RegCmdB: prdata = ApbDataW'(cfg_q.command_id_b);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/cit_update.sv =====
`timescale 1ns / 1ps
module cit_update (
  input  cit_pkg::cit_req_t   req_i,
  input  cit_pkg::cit_cfg_t   cfg_i,
  input  cit_pkg::cit_entry_t old_i,
  input  logic                fresh_i,
  output cit_pkg::cit_entry_t new_o,
  output logic                changed_o
);
  import cit_pkg::*;

  cit_entry_t           old;
  logic [CountW-1:0]    len;
  logic [CountW-1:0]    cmp_len;
  logic                 is_cmd;
  logic [DataW-1:0]     cmp_mask;
  logic [DataW-1:0]     st_mask;

  always_comb begin
    // A new entry has never been written since reset: it reads as zero.
    old     = fresh_i ? '0 : old_i;
    len     = (req_i.byte_count > MaxBytes) ? MaxBytes : req_i.byte_count;
    is_cmd  = (req_i.frame_id == cfg_i.command_id_a) ||
              (req_i.frame_id == cfg_i.command_id_b);
    cmp_len = (is_cmd && len > CountW'(1)) ? len - CountW'(1) : len;
    cmp_mask = byte_mask(cmp_len);
    st_mask  = byte_mask(len);

    changed_o   = |((old.bytes ^ req_i.payload) & cmp_mask);
    new_o.bytes = (old.bytes & ~st_mask) | (req_i.payload & st_mask);
    new_o.hits  = (old.hits == HitsMax) ? old.hits : old.hits + HitsW'(1);
  end

endmodule
